// ===== hw/rtl/irc_pkg.sv =====
package irc_pkg;

    // field widths
    localparam int PSN_W   = 24;
    localparam int TS_W    = 32;
    localparam int TXB_W   = 32;
    localparam int QLEN_W  = 24;
    localparam int MBPS_W  = 20;
    localparam int RATIO_W = 17;
    localparam int UTIL_W  = 20;
    localparam int STAGE_W = 5;
    localparam int AI_W    = 16;
    localparam int RTT_W   = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_UTIL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STAGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_AI_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_REF_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RTT_NS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE_RATIO = 3'd5;

    localparam logic [RATIO_W-1:0] RST_TARGET_UTIL    = 17'd62259;
    localparam logic [STAGE_W-1:0] RST_MAX_STAGE      = 5'd5;
    localparam logic [AI_W-1:0]    RST_RATE_AI_STEP   = 16'd33;
    localparam logic [RATIO_W-1:0] RST_START_REF_RATE = 17'd65536;
    localparam logic [RTT_W-1:0]   RST_BASE_RTT_NS    = 24'd10000;
    localparam logic [RATIO_W-1:0] RST_MIN_RATE_RATIO = 17'd66;

    localparam logic [RATIO_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [UTIL_W-1:0]  UTIL_MAX = 20'hFFFFF;
    localparam logic [UTIL_W-1:0]  UTIL_ONE = 20'd65536;
    localparam logic [12:0]        BITS_X_NS = 13'd8000;

    // hop table
    localparam int MAX_HOPS_DEF = 8;

    // ingress queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // saturating divider
    localparam int DIV_NUM_W = 61;
    localparam int DIV_DEN_W = 52;
    localparam int DIV_Q_W   = UTIL_W;
    localparam int DIV_CMP_W = DIV_DEN_W + DIV_Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    typedef struct packed {
        logic [PSN_W-1:0]  ack_psn;
        logic [PSN_W-1:0]  sender_next_psn;
        logic              hop_present;
        logic [TS_W-1:0]   hop_timestamp_ns;
        logic [TXB_W-1:0]  hop_tx_bytes;
        logic [QLEN_W-1:0] hop_qlen_bytes;
        logic [MBPS_W-1:0] hop_line_rate_mbps;
        logic              last_hop;
    } t_item;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

endpackage

// ===== hw/rtl/irc_if.sv =====
interface irc_ack_if;
    logic                            valid;
    logic                            ready;
    logic [irc_pkg::PSN_W-1:0]       ack_psn;
    logic [irc_pkg::PSN_W-1:0]       sender_next_psn;
    logic                            hop_present;
    logic [irc_pkg::TS_W-1:0]        hop_timestamp_ns;
    logic [irc_pkg::TXB_W-1:0]       hop_tx_bytes;
    logic [irc_pkg::QLEN_W-1:0]      hop_qlen_bytes;
    logic [irc_pkg::MBPS_W-1:0]      hop_line_rate_mbps;
    logic                            last_hop;

    modport source (
        output valid, ack_psn, sender_next_psn, hop_present, hop_timestamp_ns,
               hop_tx_bytes, hop_qlen_bytes, hop_line_rate_mbps, last_hop,
        input  ready
    );
    modport sink (
        input  valid, ack_psn, sender_next_psn, hop_present, hop_timestamp_ns,
               hop_tx_bytes, hop_qlen_bytes, hop_line_rate_mbps, last_hop,
        output ready
    );
endinterface

interface irc_res_if;
    logic                          valid;
    logic                          ready;
    logic [irc_pkg::RATIO_W-1:0]   rate_ratio;
    logic [irc_pkg::UTIL_W-1:0]    utilization;
    logic [irc_pkg::STAGE_W-1:0]   increase_stage;
    logic                          reference_updated;

    modport source (
        output valid, rate_ratio, utilization, increase_stage, reference_updated,
        input  ready
    );
    modport sink (
        input  valid, rate_ratio, utilization, increase_stage, reference_updated,
        output ready
    );
endinterface

// ===== hw/rtl/irc_front.sv =====
module irc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    irc_ack_if.sink             i_ack,
    input  logic                i_pop,
    output logic                o_valid,
    output irc_pkg::t_item      o_item
);
    irc_pkg::t_item                 r_q [irc_pkg::QUEUE_DEPTH];
    logic [irc_pkg::QPTR_W-1:0]     r_wp;
    logic [irc_pkg::QPTR_W-1:0]     r_rp;
    logic [irc_pkg::QCNT_W-1:0]     r_cnt;
    irc_pkg::t_item                 w_in;
    logic                           w_push;
    logic                           w_pop;

    // normalize: zero line rate counts as 1 Mbps
    always_comb begin
        w_in.ack_psn            = i_ack.ack_psn;
        w_in.sender_next_psn    = i_ack.sender_next_psn;
        w_in.hop_present        = i_ack.hop_present;
        w_in.hop_timestamp_ns   = i_ack.hop_timestamp_ns;
        w_in.hop_tx_bytes       = i_ack.hop_tx_bytes;
        w_in.hop_qlen_bytes     = i_ack.hop_qlen_bytes;
        w_in.hop_line_rate_mbps = (i_ack.hop_line_rate_mbps == '0) ?
                                  irc_pkg::MBPS_W'(1) : i_ack.hop_line_rate_mbps;
        w_in.last_hop           = i_ack.last_hop;
    end

    assign i_ack.ready = (r_cnt != irc_pkg::QCNT_W'(irc_pkg::QUEUE_DEPTH));
    assign w_push      = i_ack.valid && i_ack.ready;
    assign w_pop       = i_pop && o_valid;
    assign o_valid     = (r_cnt != '0);
    assign o_item      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_in;
                r_wp      <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== hw/rtl/irc_div.sv =====
module irc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [irc_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [irc_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_done,
    output logic [irc_pkg::DIV_Q_W-1:0]     o_q
);
    localparam int NW = irc_pkg::DIV_NUM_W;
    localparam int CW = irc_pkg::DIV_CMP_W;
    localparam int QW = irc_pkg::DIV_Q_W;

    logic                           r_busy;
    logic                           r_done;
    logic [NW-1:0]                  r_rem;
    logic [CW-1:0]                  r_d;
    logic [QW-1:0]                  r_q;
    logic [irc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           w_sat;
    logic                           w_ge;

    // quotient would not fit in QW bits: saturate
    assign w_sat  = (CW'(i_num) >= {i_den, {QW{1'b0}}});
    assign w_ge   = (CW'(r_rem) >= r_d);
    assign o_done = r_done;
    assign o_q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_sat) begin
                    r_q    <= irc_pkg::UTIL_MAX;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_num;
                    r_d    <= CW'(i_den) << (QW - 1);
                    r_q    <= '0;
                    r_cnt  <= irc_pkg::DIV_CNT_W'(QW - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_d[NW-1:0];
                end
                r_q <= {r_q[QW-2:0], w_ge};
                r_d <= r_d >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/irc_back.sv =====
module irc_back #(
    parameter int MAX_HOPS = irc_pkg::MAX_HOPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [irc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  irc_pkg::t_q_ctl                 i_q,
    input  irc_pkg::t_item                  i_item,
    output logic                            o_pop,
    irc_res_if.source                       o_res
);
    localparam int HCNT_W = $clog2(MAX_HOPS + 1);
    localparam int HIDX_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int NR_W   = irc_pkg::UTIL_W + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HOP  = 4'd1;
    localparam logic [3:0] S_MA   = 4'd2;
    localparam logic [3:0] S_WA   = 4'd3;
    localparam logic [3:0] S_MB   = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_END  = 4'd6;
    localparam logic [3:0] S_EW1  = 4'd7;
    localparam logic [3:0] S_EW2  = 4'd8;
    localparam logic [3:0] S_WE   = 4'd9;
    localparam logic [3:0] S_DEC  = 4'd10;
    localparam logic [3:0] S_WD   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // configuration
    logic [irc_pkg::RATIO_W-1:0]   r_eta;
    logic [irc_pkg::STAGE_W-1:0]   r_max_stage;
    logic [irc_pkg::AI_W-1:0]      r_ai;
    logic [irc_pkg::RTT_W-1:0]     r_rtt;
    logic [irc_pkg::RATIO_W-1:0]   r_min_rate;

    // per-hop records
    logic [irc_pkg::TS_W-1:0]      r_prev_ts [MAX_HOPS];
    logic [irc_pkg::TXB_W-1:0]     r_prev_tx [MAX_HOPS];
    logic [irc_pkg::QLEN_W-1:0]    r_prev_q  [MAX_HOPS];

    // flow state
    logic [irc_pkg::PSN_W-1:0]     r_last_psn;
    logic [irc_pkg::UTIL_W-1:0]    r_util;
    logic [irc_pkg::RATIO_W-1:0]   r_ref;
    logic [irc_pkg::STAGE_W-1:0]   r_stage;
    logic [HCNT_W-1:0]             r_hidx;
    logic [irc_pkg::UTIL_W-1:0]    r_umax;
    logic [irc_pkg::TS_W-1:0]      r_tau;

    // working registers
    logic [3:0]                    r_state;
    irc_pkg::t_item                r_it;
    logic [irc_pkg::TS_W-1:0]      r_dt;
    logic [irc_pkg::TXB_W-1:0]     r_db;
    logic [irc_pkg::QLEN_W-1:0]    r_mq;
    logic [irc_pkg::UTIL_W-1:0]    r_ua;
    logic [43:0]                   r_p1;
    logic [NR_W-1:0]               r_nr;
    logic [irc_pkg::STAGE_W-1:0]   r_ns;

    // result register
    logic                          r_ov;
    logic [irc_pkg::RATIO_W-1:0]   r_o_rate;
    logic [irc_pkg::UTIL_W-1:0]    r_o_util;
    logic [irc_pkg::STAGE_W-1:0]   r_o_stage;
    logic                          r_o_upd;

    logic [irc_pkg::RTT_W-1:0]     w_rtt;
    logic [irc_pkg::RATIO_W-1:0]   w_eta;
    logic [irc_pkg::RTT_W-1:0]     w_tau;
    logic                          w_first;
    logic                          w_take_hop;
    logic [HIDX_W-1:0]             w_hi;
    logic                          w_decr;
    logic [irc_pkg::RATIO_W-1:0]   w_lo;
    logic [irc_pkg::RATIO_W-1:0]   w_clamped;
    logic                          w_upd;
    logic                          w_out_free;
    logic                          w_load_out;
    logic [irc_pkg::UTIL_W:0]      w_usum;
    logic [irc_pkg::UTIL_W-1:0]    w_uhop;

    logic                          w_div_start;
    logic [irc_pkg::DIV_NUM_W-1:0] w_div_num;
    logic [irc_pkg::DIV_DEN_W-1:0] w_div_den;
    logic                          w_div_done;
    logic [irc_pkg::DIV_Q_W-1:0]   w_div_q;

    irc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    assign w_rtt      = (r_rtt == '0) ? irc_pkg::RTT_W'(1) : r_rtt;
    assign w_eta      = (r_eta == '0) ? irc_pkg::RATIO_W'(1) : r_eta;
    assign w_tau      = (r_tau < irc_pkg::TS_W'(w_rtt)) ? r_tau[irc_pkg::RTT_W-1:0] : w_rtt;
    assign w_first    = (r_last_psn == '0);
    assign w_hi       = r_hidx[HIDX_W-1:0];
    assign w_take_hop = r_it.hop_present && (r_hidx < HCNT_W'(MAX_HOPS));
    assign w_decr     = (r_util >= irc_pkg::UTIL_W'(w_eta)) || (r_stage >= r_max_stage);
    assign w_upd      = (r_it.ack_psn > r_last_psn);
    assign w_out_free = !r_ov || o_res.ready;
    assign w_load_out = (r_state == S_OUT) && w_out_free;
    assign w_usum     = {1'b0, r_ua} + {1'b0, w_div_q};
    assign w_uhop     = w_usum[irc_pkg::UTIL_W] ? irc_pkg::UTIL_MAX
                                                : w_usum[irc_pkg::UTIL_W-1:0];

    // rate clamp to [min(max(min_rate,1),1.0), 1.0]
    always_comb begin
        w_lo = (r_min_rate == '0) ? irc_pkg::RATIO_W'(1) : r_min_rate;
        if (w_lo > irc_pkg::ONE_Q16) begin
            w_lo = irc_pkg::ONE_Q16;
        end
        if (r_nr > NR_W'(irc_pkg::ONE_Q16)) begin
            w_clamped = irc_pkg::ONE_Q16;
        end else if (r_nr < NR_W'(w_lo)) begin
            w_clamped = w_lo;
        end else begin
            w_clamped = r_nr[irc_pkg::RATIO_W-1:0];
        end
    end

    // divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (r_state)
            S_MA: begin
                w_div_start = (r_dt != '0);
                w_div_num   = irc_pkg::DIV_NUM_W'({45'(r_db) * 45'(irc_pkg::BITS_X_NS),
                                                   16'b0});
                w_div_den   = irc_pkg::DIV_DEN_W'(r_dt) *
                              irc_pkg::DIV_DEN_W'(r_it.hop_line_rate_mbps);
            end
            S_MB: begin
                w_div_start = 1'b1;
                w_div_num   = irc_pkg::DIV_NUM_W'({37'(r_mq) * 37'(irc_pkg::BITS_X_NS),
                                                   16'b0});
                w_div_den   = irc_pkg::DIV_DEN_W'(w_rtt) *
                              irc_pkg::DIV_DEN_W'(r_it.hop_line_rate_mbps);
            end
            S_EW2: begin
                w_div_start = 1'b1;
                w_div_num   = irc_pkg::DIV_NUM_W'({1'b0, r_p1} + 45'(r_umax) * 45'(w_tau));
                w_div_den   = irc_pkg::DIV_DEN_W'(w_rtt);
            end
            S_DEC: begin
                w_div_start = w_decr && (r_util != '0);
                w_div_num   = irc_pkg::DIV_NUM_W'(34'(r_ref) * 34'(w_eta));
                w_div_den   = irc_pkg::DIV_DEN_W'(r_util);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && i_q.valid;

    assign o_res.valid             = r_ov;
    assign o_res.rate_ratio        = r_o_rate;
    assign o_res.utilization       = r_o_util;
    assign o_res.increase_stage    = r_o_stage;
    assign o_res.reference_updated = r_o_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta       <= irc_pkg::RST_TARGET_UTIL;
            r_max_stage <= irc_pkg::RST_MAX_STAGE;
            r_ai        <= irc_pkg::RST_RATE_AI_STEP;
            r_rtt       <= irc_pkg::RST_BASE_RTT_NS;
            r_min_rate  <= irc_pkg::RST_MIN_RATE_RATIO;
            r_ref       <= irc_pkg::RST_START_REF_RATE;
            for (int k = 0; k < MAX_HOPS; k++) begin
                r_prev_ts[k] <= '0;
                r_prev_tx[k] <= '0;
                r_prev_q[k]  <= '0;
            end
            r_last_psn <= '0;
            r_util     <= irc_pkg::UTIL_ONE;
            r_stage    <= '0;
            r_hidx     <= '0;
            r_umax     <= '0;
            r_tau      <= '0;
            r_state    <= S_IDLE;
            r_ov       <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    irc_pkg::REG_TARGET_UTIL:    r_eta <= i_cfg_data[irc_pkg::RATIO_W-1:0];
                    irc_pkg::REG_MAX_STAGE:      r_max_stage <= i_cfg_data[irc_pkg::STAGE_W-1:0];
                    irc_pkg::REG_RATE_AI_STEP:   r_ai <= i_cfg_data[irc_pkg::AI_W-1:0];
                    irc_pkg::REG_START_REF_RATE: r_ref <= i_cfg_data[irc_pkg::RATIO_W-1:0];
                    irc_pkg::REG_BASE_RTT_NS:    r_rtt <= i_cfg_data[irc_pkg::RTT_W-1:0];
                    irc_pkg::REG_MIN_RATE_RATIO: r_min_rate <= i_cfg_data[irc_pkg::RATIO_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_it    <= i_item;
                        r_state <= S_HOP;
                    end
                end
                S_HOP: begin
                    if (w_take_hop) begin
                        r_dt <= r_it.hop_timestamp_ns - r_prev_ts[w_hi];
                        r_db <= r_it.hop_tx_bytes - r_prev_tx[w_hi];
                        r_mq <= (r_it.hop_qlen_bytes < r_prev_q[w_hi]) ?
                                r_it.hop_qlen_bytes : r_prev_q[w_hi];
                        r_prev_ts[w_hi] <= r_it.hop_timestamp_ns;
                        r_prev_tx[w_hi] <= r_it.hop_tx_bytes;
                        r_prev_q[w_hi]  <= r_it.hop_qlen_bytes;
                        r_hidx          <= r_hidx + 1'b1;
                    end
                    r_state <= (w_take_hop && !w_first) ? S_MA : S_END;
                end
                S_MA: begin
                    if (r_dt == '0) begin
                        r_ua    <= (r_db != '0) ? irc_pkg::UTIL_MAX : '0;
                        r_state <= S_MB;
                    end else begin
                        r_state <= S_WA;
                    end
                end
                S_WA: begin
                    if (w_div_done) begin
                        r_ua    <= w_div_q;
                        r_state <= S_MB;
                    end
                end
                S_MB: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (w_div_done) begin
                        if (w_uhop > r_umax) begin
                            r_umax <= w_uhop;
                            r_tau  <= r_dt;
                        end
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (!r_it.last_hop) begin
                        r_state <= S_IDLE;
                    end else if (w_first) begin
                        r_last_psn <= r_it.sender_next_psn;
                        r_hidx     <= '0;
                        r_umax     <= '0;
                        r_tau      <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_EW1;
                    end
                end
                S_EW1: begin
                    r_p1    <= 44'(r_util) * 44'(w_rtt - w_tau);
                    r_state <= S_EW2;
                end
                S_EW2: begin
                    r_state <= S_WE;
                end
                S_WE: begin
                    if (w_div_done) begin
                        r_util  <= w_div_q;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (w_decr) begin
                        r_ns <= '0;
                        if (r_util == '0) begin
                            r_nr    <= NR_W'(irc_pkg::ONE_Q16);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WD;
                        end
                    end else begin
                        r_nr    <= NR_W'(r_ref) + NR_W'(r_ai);
                        r_ns    <= r_stage + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_WD: begin
                    if (w_div_done) begin
                        r_nr    <= NR_W'(w_div_q) + NR_W'(r_ai);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_rate  <= w_clamped;
                        r_o_util  <= r_util;
                        r_o_stage <= r_ns;
                        r_o_upd   <= w_upd;
                        if (w_upd) begin
                            r_ref      <= w_clamped;
                            r_stage    <= r_ns;
                            r_last_psn <= r_it.sender_next_psn;
                        end
                        r_hidx  <= '0;
                        r_umax  <= '0;
                        r_tau   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/int_rate_controller_top.sv =====
// HPCC sender rate controller. Each ACK enters as a run of per-hop telemetry
// transactions on i_ack, the final one flagged by last_hop; the final
// transaction of every ACK after the first returns one result transaction
// on o_res (new rate ratio Q1.16, smoothed utilization Q4.16, increase stage,
// commit flag). A four-entry queue takes transactions while the engine works,
// so i_ack keeps accepting until the queue fills. The engine handles one
// transaction at a time: a hop record takes two passes of the shared
// 20-step saturating divider (byte term and queue term), only the queue term
// when the time delta is zero; a hop-less or first-ACK transaction skips the
// divider; the closing transaction of an ACK adds divisions for the average
// update and the decrease (the average update alone on an increase), and the
// result may then wait on o_res.ready. Configuration writes are
// taken at any time but must be issued only while the block is idle; writing
// start_ref_rate also reloads the reference rate.
module int_rate_controller_top #(
    parameter int MAX_HOPS = irc_pkg::MAX_HOPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [irc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    irc_ack_if.sink                         i_ack,
    irc_res_if.source                       o_res
);
    irc_pkg::t_item  w_item;
    irc_pkg::t_q_ctl w_q;
    logic            w_valid;
    logic            w_pop;

    // front end: ingress queue with line-rate normalization
    irc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ack   (i_ack),
        .i_pop   (w_pop),
        .o_valid (w_valid),
        .o_item  (w_item)
    );

    assign w_q.valid = w_valid;
    assign w_q.pop   = w_pop;

    // back end: hop table, divider and rate update
    irc_back #(
        .MAX_HOPS (MAX_HOPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q        (w_q),
        .i_item     (w_item),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );
endmodule
